// File: rtl/ypdt_pkg.sv
package ypdt_pkg;

  // Field widths.
  localparam int ANGLE_W = 17;
  localparam int SPEED_W = 16;
  localparam int DT_W    = 20;
  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 30;
  localparam int DRIVE_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Internal widths.
  localparam int WRAP_W  = ANGLE_W + 1;    // raw heading difference
  localparam int ERR_W   = 16;             // wrapped error, +-23040
  localparam int INTEG_W = 32;             // integrator state
  localparam int ACC_W   = 38;             // integrator plus err*dt before clamping
  localparam int DT_FRAC = 16;             // fraction bits of the time step
  localparam int QUO_W   = ERR_W + DT_FRAC;
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int DERIV_W = QUO_W + 1;
  localparam int PROD_W  = GAIN_W + DERIV_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int GAIN_FRAC = 16;
  localparam int STEER_SHIFT = 9;

  localparam logic signed [WRAP_W-1:0]  HALF_TURN  = 23040;
  localparam logic signed [WRAP_W-1:0]  FULL_TURN  = 46080;
  localparam logic signed [WRAP_W-1:0]  ERROR_IDLE = 640;
  localparam logic signed [SUM_W-1:0]   STEER_MAX  = 9830;
  localparam logic signed [SPEED_W:0]   DRIVE_MAX  = 16384;
  localparam logic signed [SPEED_W-1:0] SPEED_IDLE = 820;

  localparam logic signed [GAIN_W-1:0]  GAIN_P_RST = 52429;
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RST = 3277;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RST = 13107;
  localparam logic [LIMIT_W-1:0]        LIMIT_RST  = 2516582;

  typedef enum logic [1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [QUO_W-1:0]  dividend;
    logic [DT_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [DERIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ypdt_divider.sv
module ypdt_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  ypdt_pkg::div_req_t req,
  output ypdt_pkg::div_rsp_t rsp
);
  import ypdt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DT_W-1:0]   rem_r;
  logic [DT_W-1:0]   dsor_r;
  logic [DT_W+1:0]   trial;
  logic              fits;
  logic signed [DERIV_W-1:0] quo_ext;

  // Restoring division: the dividend shifts out of the top of quo_r while
  // quotient bits shift in at the bottom, one bit per cycle.
  assign trial   = {1'b0, rem_r, quo_r[QUO_W-1]} - {2'b00, dsor_r};
  assign fits    = ~trial[DT_W+1];
  assign quo_ext = $signed({1'b0, quo_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_ext : quo_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(QUO_W - 1);
      neg_r  <= req.neg;
      quo_r  <= req.dividend;
      dsor_r <= req.divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DT_W-1:0] : {rem_r[DT_W-2:0], quo_r[QUO_W-1]};
      quo_r <= {quo_r[QUO_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/yaw_pid_differential_thrust.sv
// Yaw heading PID controller with differential thrust output.
// Input channel (in_valid / in_stall): current heading, target heading,
// forward speed and time step. One transfer on the input gives exactly one
// transfer on the output channel (out_valid / out_stall) carrying the left
// and right drive commands.
// Gains and the integrator bound are written over the APB-style port; the
// user must write them only while the block is idle, which the block does
// not enforce itself. Writing any gain clears the integrator.
// The block works on one item at a time and holds in_stall high meanwhile.
// An item passes through the heading wrap (more corrections for headings
// beyond a full turn), the restoring divider that forms the derivative
// term, and the one shared multiplier that forms err*dt and the three gain
// products; in_stall falls as the result is loaded into the output register.
// A zero time step skips all of that and gives zero drives from the output state.
// The output register frees the input side: a new item is taken while the
// previous result still waits. When the receiver stalls with a result
// already waiting, the next result is held inside until that one transfers.
// Reset restores the default gains and bound and clears the integrator,
// the stored previous error and the output valid flag.
module yaw_pid_differential_thrust (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [ypdt_pkg::ANGLE_W-1:0]      in_heading_now,
  input  logic signed [ypdt_pkg::ANGLE_W-1:0]      in_heading_goal,
  input  logic signed [ypdt_pkg::SPEED_W-1:0]      in_forward_speed,
  input  logic        [ypdt_pkg::DT_W-1:0]         in_time_step,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ypdt_pkg::DRIVE_W-1:0]      out_left_drive,
  output logic signed [ypdt_pkg::DRIVE_W-1:0]      out_right_drive,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic        [ypdt_pkg::ADDR_W-1:0]       paddr,
  input  logic        [ypdt_pkg::DATA_W-1:0]       pwdata,
  output logic        [ypdt_pkg::DATA_W-1:0]       prdata,
  output logic                                     pready
);
  import ypdt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_MUL_INT,
    S_ACC_INT,
    S_MUL_KI,
    S_ACC_KI,
    S_WAIT_DIV,
    S_MUL_KD,
    S_ACC_KD,
    S_OUT
  } state_t;

  state_t state_r;

  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic        [LIMIT_W-1:0] limit_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_err_r;

  logic signed [WRAP_W-1:0]  err_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic        [DT_W-1:0]    dt_r;
  logic                      zero_r;
  logic signed [PROD_W-1:0]  mul_p_r;
  logic signed [SUM_W-1:0]   sum_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_left_r, out_right_r;

  // Configuration port.
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_P: prdata = DATA_W'(gain_p_r);
      REG_GAIN_I: prdata = DATA_W'(gain_i_r);
      REG_GAIN_D: prdata = DATA_W'(gain_d_r);
      REG_LIMIT:  prdata = DATA_W'(limit_r);
      default:    prdata = '0;
    endcase
  end

  // Shared multiplier with a registered product.
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [DERIV_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_full;
  div_rsp_t                  div_rsp;

  always_comb begin
    unique case (state_r)
      S_MUL_INT: begin
        mul_a = GAIN_W'(err_r);
        mul_b = $signed(DERIV_W'(dt_r));
      end
      S_ACC_INT: begin
        mul_a = gain_p_r;
        mul_b = DERIV_W'(err_r);
      end
      S_MUL_KI: begin
        mul_a = gain_i_r;
        mul_b = DERIV_W'(integ_r);
      end
      default: begin
        mul_a = gain_d_r;
        mul_b = div_rsp.quotient;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Integrator update with anti-windup clamp.
  logic signed [ACC_W-1:0]   integ_acc, lim_pos, lim_neg, integ_clamped;

  assign integ_acc = ACC_W'(integ_r) + mul_p_r[ACC_W-1:0];
  assign lim_pos   = $signed(ACC_W'(limit_r));
  assign lim_neg   = -lim_pos;

  always_comb begin
    priority if (integ_acc > lim_pos) integ_clamped = lim_pos;
    else if (integ_acc < lim_neg)     integ_clamped = lim_neg;
    else                              integ_clamped = integ_acc;
  end

  // Derivative divider request: |err - prev| * 2^16 / dt.
  logic signed [ERR_W:0] err_diff;
  logic        [ERR_W:0] diff_mag;
  div_req_t              div_req;

  assign err_diff = (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_err_r);
  assign diff_mag = err_diff[ERR_W] ? -err_diff : err_diff;

  assign div_req.start    = (state_r == S_ACC_INT);
  assign div_req.neg      = err_diff[ERR_W];
  assign div_req.dividend = {diff_mag[ERR_W-1:0], {DT_FRAC{1'b0}}};
  assign div_req.divisor  = dt_r;

  ypdt_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Integral term rounded toward zero.
  logic signed [PROD_W-1:0] ki_bias;
  logic signed [PROD_W-1:0] ki_term;

  assign ki_bias = mul_p_r + (mul_p_r[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : '0);
  assign ki_term = ki_bias >>> GAIN_FRAC;

  // Steering and drive outputs.
  logic signed [SUM_W-1:0]   sum_bias, steer_raw, steer_cl;
  logic signed [SPEED_W-1:0] steer;
  logic signed [SPEED_W:0]   left_sum, right_sum, left_cl, right_cl;
  logic                      dead_zone;

  assign sum_bias  = sum_r + (sum_r[SUM_W-1] ? SUM_W'((1 << STEER_SHIFT) - 1) : '0);
  assign steer_raw = sum_bias >>> STEER_SHIFT;

  always_comb begin
    priority if (steer_raw > STEER_MAX) steer_cl = STEER_MAX;
    else if (steer_raw < -STEER_MAX)    steer_cl = -STEER_MAX;
    else                                steer_cl = steer_raw;
  end

  assign steer     = SPEED_W'(steer_cl);
  assign left_sum  = (SPEED_W+1)'(speed_r) + (SPEED_W+1)'(steer);
  assign right_sum = (SPEED_W+1)'(speed_r) - (SPEED_W+1)'(steer);

  always_comb begin
    priority if (left_sum > DRIVE_MAX) left_cl = DRIVE_MAX;
    else if (left_sum < -DRIVE_MAX)    left_cl = -DRIVE_MAX;
    else                               left_cl = left_sum;
    priority if (right_sum > DRIVE_MAX) right_cl = DRIVE_MAX;
    else if (right_sum < -DRIVE_MAX)    right_cl = -DRIVE_MAX;
    else                                right_cl = right_sum;
  end

  assign dead_zone = (speed_r < SPEED_IDLE) && (err_r < ERROR_IDLE) && (err_r > -ERROR_IDLE);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      limit_r     <= LIMIT_RST;
      integ_r     <= '0;
      prev_err_r  <= '0;
      zero_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r   <= WRAP_W'(in_heading_goal) - WRAP_W'(in_heading_now);
            speed_r <= in_forward_speed;
            dt_r    <= in_time_step;
            zero_r  <= (in_time_step == '0);
            state_r <= (in_time_step == '0) ? S_OUT : S_WRAP;
          end
        end
        S_WRAP: begin
          priority if (err_r > HALF_TURN) begin
            err_r <= err_r - FULL_TURN;
          end else if (err_r < -HALF_TURN) begin
            err_r <= err_r + FULL_TURN;
          end else begin
            state_r <= S_MUL_INT;
          end
        end
        S_MUL_INT: begin
          mul_p_r <= mul_full;
          state_r <= S_ACC_INT;
        end
        S_ACC_INT: begin
          // The divider starts in this cycle from the old previous error.
          integ_r    <= INTEG_W'(integ_clamped);
          prev_err_r <= ERR_W'(err_r);
          mul_p_r    <= mul_full;
          state_r    <= S_MUL_KI;
        end
        S_MUL_KI: begin
          sum_r   <= SUM_W'(mul_p_r);
          mul_p_r <= mul_full;
          state_r <= S_ACC_KI;
        end
        S_ACC_KI: begin
          sum_r   <= sum_r + SUM_W'(ki_term);
          state_r <= S_WAIT_DIV;
        end
        S_WAIT_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_MUL_KD;
          end
        end
        S_MUL_KD: begin
          mul_p_r <= mul_full;
          state_r <= S_ACC_KD;
        end
        S_ACC_KD: begin
          sum_r   <= sum_r + SUM_W'(mul_p_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (zero_r || dead_zone) begin
              out_left_r  <= '0;
              out_right_r <= '0;
            end else begin
              out_left_r  <= DRIVE_W'(left_cl);
              out_right_r <= DRIVE_W'(right_cl);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_GAIN_P: begin
            gain_p_r <= pwdata[GAIN_W-1:0];
            integ_r  <= '0;
          end
          REG_GAIN_I: begin
            gain_i_r <= pwdata[GAIN_W-1:0];
            integ_r  <= '0;
          end
          REG_GAIN_D: begin
            gain_d_r <= pwdata[GAIN_W-1:0];
            integ_r  <= '0;
          end
          REG_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ypdt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic signed [ANGLE_W-1:0] now;
    logic signed [ANGLE_W-1:0] goal;
    logic signed [SPEED_W-1:0] speed;
    logic        [DT_W-1:0]    dt;
  } heading_item_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drv_left;
    logic signed [DRIVE_W-1:0] drv_right;
  } drive_pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_heading_now = '0;
  logic signed [ANGLE_W-1:0] in_heading_goal = '0;
  logic signed [SPEED_W-1:0] in_forward_speed = '0;
  logic        [DT_W-1:0]    in_time_step = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_left_drive;
  logic signed [DRIVE_W-1:0] out_right_drive;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic        [ADDR_W-1:0]  paddr = '0;
  logic        [DATA_W-1:0]  pwdata = '0;
  logic        [DATA_W-1:0]  prdata;
  logic                      pready;

  // Controller copy: gains, windup bound and loop state.
  longint kp, ki, kd, windup_limit;
  longint heading_integral, last_heading_error;

  drive_pair_t expected_drives[$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  register_writes = 0;
  int  cycle_count = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b1;
  bit  hold_pending = 1'b0;
  int  hold_count = 0;
  int  stall_wait = 0;

  yaw_pid_differential_thrust uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_heading_now   (in_heading_now),
    .in_heading_goal  (in_heading_goal),
    .in_forward_speed (in_forward_speed),
    .in_time_step     (in_time_step),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_drive   (out_left_drive),
    .out_right_drive  (out_right_drive),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_drives.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the controller copy by one accepted item and returns its drives.
  function automatic drive_pair_t predict_drives(heading_item_t it);
    drive_pair_t res;
    longint dt, err, rate, total, steer, spd, lft, rgt;
    res.drv_left = '0;
    res.drv_right = '0;
    dt = longint'(it.dt);
    if (dt == 0) return res;

    err = longint'(it.goal) - longint'(it.now);
    while (err > 23040) err -= 46080;
    while (err < -23040) err += 46080;

    heading_integral = clamp_to(heading_integral + err * dt, -windup_limit, windup_limit);
    rate = ((err - last_heading_error) * 65536) / dt;
    last_heading_error = err;

    total = kp * err + (ki * heading_integral) / 65536 + kd * rate;
    steer = clamp_to(total / 512, -9830, 9830);
    spd = longint'(it.speed);
    lft = clamp_to(spd + steer, -16384, 16384);
    rgt = clamp_to(spd - steer, -16384, 16384);
    // Slow and nearly on course: motors off, state still advances.
    if (spd < 820 && err > -640 && err < 640) begin
      lft = 0;
      rgt = 0;
    end
    res.drv_left = lft[DRIVE_W-1:0];
    res.drv_right = rgt[DRIVE_W-1:0];
    return res;
  endfunction

  function automatic heading_item_t make_item(int now, int goal, int speed, int dt);
    heading_item_t it;
    it.now = ANGLE_W'(now);
    it.goal = ANGLE_W'(goal);
    it.speed = SPEED_W'(speed);
    it.dt = DT_W'(dt);
    return it;
  endfunction

  // Mostly plausible control-loop traffic, plus raw noise and zero time steps.
  function automatic heading_item_t random_heading_item();
    heading_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.now = ANGLE_W'($urandom);
    it.goal = ANGLE_W'($urandom);
    it.speed = SPEED_W'($urandom);
    it.dt = DT_W'($urandom);
    if (pick < 8) return it;
    if (pick < 12) begin
      it.dt = '0;
      return it;
    end
    it.now = ANGLE_W'(int'($urandom_range(0, 92159)) - 46080);
    if (pick < 30) begin
      it.goal = ANGLE_W'(int'(it.now) + int'($urandom_range(0, 1500)) - 750);
      it.speed = SPEED_W'(int'($urandom_range(0, 1100)) - 200);
    end else begin
      if (pick < 50)
        it.goal = ANGLE_W'(int'($urandom_range(0, 92159)) - 46080);
      else
        it.goal = ANGLE_W'(int'(it.now) + int'($urandom_range(0, 8000)) - 4000);
      it.speed = SPEED_W'(int'($urandom_range(0, 24576)) - 8192);
    end
    if ($urandom_range(0, 4) == 0)
      it.dt = DT_W'($urandom_range(1, 64));
    else
      it.dt = DT_W'($urandom_range(1, 13107));
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] random_gain();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return DATA_W'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic logic [DATA_W-1:0] random_limit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2 ** LIMIT_W - 1);
      1: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 50000000);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the item transfers.
  task automatic send_heading(input heading_item_t it);
    int gap;
    gap = sender_idles ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_heading_now <= it.now;
    in_heading_goal <= it.goal;
    in_forward_speed <= it.speed;
    in_time_step <= it.dt;
    do @(posedge clk); while (in_stall);
    expected_drives.push_back(predict_drives(it));
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_register(input reg_idx_t idx, input logic [DATA_W-1:0] want);
    int width;
    logic [DATA_W-1:0] mask;
    width = (idx == REG_LIMIT) ? LIMIT_W : GAIN_W;
    mask = (DATA_W'(1) << width) - 1;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (want & mask))
      report_mismatch($sformatf("register %s reads 0x%0h, wrote 0x%0h",
                                idx.name(), prdata & mask, want & mask));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the block idle. Gain writes also clear the integrator.
  task automatic configure_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_P: begin
        kp = longint'($signed(value[GAIN_W-1:0]));
        heading_integral = 0;
      end
      REG_GAIN_I: begin
        ki = longint'($signed(value[GAIN_W-1:0]));
        heading_integral = 0;
      end
      REG_GAIN_D: begin
        kd = longint'($signed(value[GAIN_W-1:0]));
        heading_integral = 0;
      end
      REG_LIMIT: windup_limit = longint'(value[LIMIT_W-1:0]);
      default: ;
    endcase
    register_writes++;
    check_register(idx, value);
  endtask

  task automatic set_controller(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] i,
                                input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] lim);
    configure_register(REG_GAIN_P, p);
    configure_register(REG_GAIN_I, i);
    configure_register(REG_GAIN_D, d);
    configure_register(REG_LIMIT, lim);
  endtask

  always @(posedge clk) begin
    if (hold_pending) begin
      hold_count = LONG_HOLD;
      hold_pending = 1'b0;
    end
    if (out_valid && !out_stall)
      stall_wait = receiver_stalls ? $urandom_range(0, 7) : 0;
    if (hold_count > 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else if (stall_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid) stall_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    drive_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected result left=%0d right=%0d",
                                  out_left_drive, out_right_drive));
      end else begin
        want = expected_drives.pop_front();
        if (out_left_drive !== want.drv_left)
          report_mismatch($sformatf("left drive %0d, expected %0d",
                                    out_left_drive, want.drv_left));
        if (out_right_drive !== want.drv_right)
          report_mismatch($sformatf("right drive %0d, expected %0d",
                                    out_right_drive, want.drv_right));
        results_checked++;
      end
    end
  end

  task automatic test_register_defaults();
    check_register(REG_GAIN_P, DATA_W'(GAIN_P_RST));
    check_register(REG_GAIN_I, DATA_W'(GAIN_I_RST));
    check_register(REG_GAIN_D, DATA_W'(GAIN_D_RST));
    check_register(REG_LIMIT, DATA_W'(LIMIT_RST));
  endtask

  task automatic test_directed_cases();
    // Dead zone and its edges on either side.
    send_heading(make_item(0, 0, 0, 6554));
    send_heading(make_item(0, 639, 819, 6554));
    send_heading(make_item(0, -639, -32768, 6554));
    send_heading(make_item(0, 640, 0, 6554));
    send_heading(make_item(0, 0, 820, 6554));
    // Exactly half a turn stays put; one step past it wraps.
    send_heading(make_item(0, 23040, 8192, 655));
    send_heading(make_item(0, -23040, 8192, 655));
    send_heading(make_item(0, 23041, 8192, 655));
    send_heading(make_item(-46080, 46079, 16384, 65536));
    send_heading(make_item(46079, -46080, -16384, 65536));
    // Headings beyond a full turn need a third correction.
    send_heading(make_item(-65536, 65535, 0, 3277));
    send_heading(make_item(65535, -65536, 32767, 3277));
    // A zero time step must not disturb the stored error.
    send_heading(make_item(1000, -5000, 32767, 0));
    send_heading(make_item(1000, -5000, 32767, 1));
    send_heading(make_item(0, 12800, -32768, 1048575));
    send_heading(make_item(0, 12800, 32767, 1048575));
    send_heading(make_item(0, -12800, 16384, 3277));
    send_heading(make_item(0, 0, -32768, 0));
    send_heading(make_item(5000, 5000, 4000, 1));
    wait_for_drain();
  endtask

  task automatic test_gain_extremes();
    set_controller(32'sd8388607, -32'sd8388608, 32'd0, 32'd1073741823);
    repeat (30) send_heading(random_heading_item());
    wait_for_drain();
    set_controller(-32'sd8388608, 32'sd8388607, 32'sd8388607, 32'd0);
    repeat (30) send_heading(random_heading_item());
    wait_for_drain();
    set_controller(32'd0, 32'd0, -32'sd8388608, 32'd1);
    repeat (30) send_heading(random_heading_item());
    wait_for_drain();
  endtask

  task automatic test_windup_limit();
    set_controller(32'd0, 32'd65536, 32'd0, 32'd1073741823);
    repeat (10) send_heading(make_item(0, 20000, 4096, 1048575));
    wait_for_drain();
    // A new bound takes effect on the next step; the integrator is not cleared.
    configure_register(REG_LIMIT, 32'd1000);
    repeat (3) send_heading(make_item(0, 100, 4096, 655));
    repeat (3) send_heading(make_item(0, -22000, 4096, 1048575));
    wait_for_drain();
    set_controller(DATA_W'(GAIN_P_RST), DATA_W'(GAIN_I_RST),
                   DATA_W'(GAIN_D_RST), DATA_W'(LIMIT_RST));
  endtask

  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    hold_pending = 1'b1;
    repeat (24) send_heading(random_heading_item());
    wait_for_drain();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      set_controller(random_gain(), random_gain(), random_gain(), random_limit());
      sender_idles = $urandom_range(0, 2) != 0;
      receiver_stalls = $urandom_range(0, 2) != 0;
      repeat (150) send_heading(random_heading_item());
      wait_for_drain();
    end
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    kp = longint'(GAIN_P_RST);
    ki = longint'(GAIN_I_RST);
    kd = longint'(GAIN_D_RST);
    windup_limit = longint'(LIMIT_RST);
    heading_integral = 0;
    last_heading_error = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_directed_cases();
    test_gain_extremes();
    test_windup_limit();
    test_output_backpressure();
    test_random_traffic();

    wait_for_drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d headings and checked %0d drive pairs across %0d register writes,",
             items_sent, results_checked, register_writes);
    $display("including gain extremes, windup bounds, wrap, dead zone and a long output hold.");
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: yaw_pid_differential_thrust.f
rtl/ypdt_pkg.sv
rtl/ypdt_divider.sv
rtl/yaw_pid_differential_thrust.sv
dv/testbench.sv
